@@ rtl/lpps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpps_pkg
// Shared types and constants for the line position PD steering block.
// ----------------------------------------------------------------------------
package lpps_pkg;

    localparam int PIN_W                = 8;
    localparam int SENSOR_COUNT_DEFAULT = 8;
    localparam int PWM_TOP_DEFAULT      = 1000;
    localparam int DUTY_FIELD_MAX       = 1023;

    localparam int SUM_W   = 7;
    localparam int CNT_W   = 4;
    localparam int POS_W   = 7;
    localparam int ERR_W   = 9;
    localparam int DIFF_W  = 10;
    localparam int CORR_W  = 10;
    localparam int DUTY_W  = 10;
    localparam int SPD_W   = 12;
    localparam int PROD_W  = 32;
    localparam int SCALE_W = 15;

    // 40/3 as a fixed-point reciprocal: 40 * ceil(2^17 / 3), shift by 17
    localparam int          SCALE_SHIFT = 17;
    localparam logic [20:0] SCALE_MULT  = 21'd1747640;

    localparam int QUEUE_DEPTH = 2;

    localparam int          IDX_W            = 3;
    localparam int          DATA_W           = 8;
    localparam logic [IDX_W-1:0] REG_KP_GAIN       = 3'd0;
    localparam logic [IDX_W-1:0] REG_KD_GAIN       = 3'd1;
    localparam logic [IDX_W-1:0] REG_SETPOINT      = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOST_POSITION = 3'd3;
    localparam logic [IDX_W-1:0] REG_BASE_SPEED    = 3'd4;

    localparam logic [7:0] KP_RESET    = 8'd16;
    localparam logic [7:0] KD_RESET    = 8'd0;
    localparam logic [4:0] SETP_RESET  = 5'd14;
    localparam logic [6:0] LOST_RESET  = 7'd100;
    localparam logic [7:0] BASE_RESET  = 8'd100;

    typedef struct packed {
        logic [7:0] kp_gain;
        logic [7:0] kd_gain;
        logic [4:0] setpoint;
        logic [6:0] lost_position;
        logic [7:0] base_speed;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } sample_t;

    typedef struct packed {
        logic pop;
    } queue_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PD,
        ST_SUM,
        ST_DUTY,
        ST_OUT
    } state_t;

endpackage

@@ rtl/line_position_pd_steering.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_position_pd_steering
// Line sensor position, PD steering correction and motor duty values.
// ----------------------------------------------------------------------------
//   channel   signals                                   direction
//   input     in_valid, in_stall, raw_pins              word in
//   output    out_valid, out_stall, position, line_lost,
//             correction, left_duty, right_duty         word out
//   config    cfg_wr_en, cfg_index, cfg_data            write only
//
// A word runs from leaving the queue to its result through one load,
// seven steps of the bit-serial position divider, three arithmetic steps
// and one output load; a word with no sensor on the line skips the
// divider. Reset loads the register defaults and clears the previous
// error. A two-word queue parts the front from the back; in_stall rises
// when it is full, and out_stall holds the result register.
// ----------------------------------------------------------------------------
module line_position_pd_steering #(
    parameter int SENSOR_COUNT = lpps_pkg::SENSOR_COUNT_DEFAULT,
    parameter int PWM_TOP      = lpps_pkg::PWM_TOP_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lpps_pkg::IDX_W-1:0]          cfg_index,
    input  logic [lpps_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lpps_pkg::PIN_W-1:0]          raw_pins,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lpps_pkg::POS_W-1:0]          position,
    output logic                                line_lost,
    output logic signed [lpps_pkg::CORR_W-1:0]  correction,
    output logic [lpps_pkg::DUTY_W-1:0]         left_duty,
    output logic [lpps_pkg::DUTY_W-1:0]         right_duty
);

    lpps_pkg::cfg_t       cfg_reg;
    lpps_pkg::sample_t    sample, q_data;
    lpps_pkg::queue_ctl_t q_ctl;
    logic                 q_full, q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain       <= lpps_pkg::KP_RESET;
            cfg_reg.kd_gain       <= lpps_pkg::KD_RESET;
            cfg_reg.setpoint      <= lpps_pkg::SETP_RESET;
            cfg_reg.lost_position <= lpps_pkg::LOST_RESET;
            cfg_reg.base_speed    <= lpps_pkg::BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lpps_pkg::REG_KP_GAIN:       cfg_reg.kp_gain       <= cfg_data;
                lpps_pkg::REG_KD_GAIN:       cfg_reg.kd_gain       <= cfg_data;
                lpps_pkg::REG_SETPOINT:      cfg_reg.setpoint      <= cfg_data[4:0];
                lpps_pkg::REG_LOST_POSITION: cfg_reg.lost_position <= cfg_data[6:0];
                lpps_pkg::REG_BASE_SPEED:    cfg_reg.base_speed    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = q_full;

    lpps_front #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_front (
        .raw_pins (raw_pins),
        .sample   (sample)
    );

    lpps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (sample),
        .full      (q_full),
        .pop       (q_ctl.pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    lpps_back #(
        .PWM_TOP (PWM_TOP)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_data      (q_data),
        .q_not_empty (q_not_empty),
        .q_ctl       (q_ctl),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .line_lost   (line_lost),
        .correction  (correction),
        .left_duty   (left_duty),
        .right_duty  (right_duty)
    );

endmodule

@@ rtl/lpps_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpps_front
// Classifies a pin sample: weight sum and count of sensors on the line.
// ----------------------------------------------------------------------------
module lpps_front #(
    parameter int SENSOR_COUNT = lpps_pkg::SENSOR_COUNT_DEFAULT
) (
    input  logic [lpps_pkg::PIN_W-1:0] raw_pins,
    output lpps_pkg::sample_t          sample
);

    localparam int USED = (SENSOR_COUNT < lpps_pkg::PIN_W) ? SENSOR_COUNT
                                                           : lpps_pkg::PIN_W;

    always_comb
    begin
        sample.sum   = '0;
        sample.count = '0;
        for (int n = 0; n < USED; n++)
        begin
            if (!raw_pins[n])
            begin
                sample.sum   = sample.sum + lpps_pkg::SUM_W'(4 * n);
                sample.count = sample.count + lpps_pkg::CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/lpps_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpps_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module lpps_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lpps_pkg::sample_t      push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output lpps_pkg::sample_t      pop_data
);

    localparam int PTR_W = (lpps_pkg::QUEUE_DEPTH > 1) ? $clog2(lpps_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(lpps_pkg::QUEUE_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_V = FILL_W'(lpps_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_V  = PTR_W'(lpps_pkg::QUEUE_DEPTH - 1);

    lpps_pkg::sample_t   mem_reg [lpps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full      = (fill_reg == DEPTH_V);
    assign not_empty = (fill_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_V) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_V) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + FILL_W'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/lpps_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpps_back
// Divides out the position, runs the PD law and scales the motor duties.
// ----------------------------------------------------------------------------
module lpps_back #(
    parameter int PWM_TOP = lpps_pkg::PWM_TOP_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lpps_pkg::cfg_t               cfg,
    input  lpps_pkg::sample_t            q_data,
    input  logic                         q_not_empty,
    output lpps_pkg::queue_ctl_t         q_ctl,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lpps_pkg::POS_W-1:0]   position,
    output logic                         line_lost,
    output logic signed [lpps_pkg::CORR_W-1:0] correction,
    output logic [lpps_pkg::DUTY_W-1:0]  left_duty,
    output logic [lpps_pkg::DUTY_W-1:0]  right_duty
);

    localparam int DUTY_TOP = (PWM_TOP > lpps_pkg::DUTY_FIELD_MAX) ? lpps_pkg::DUTY_FIELD_MAX
                                                                 : PWM_TOP;
    localparam logic [lpps_pkg::SCALE_W-1:0] TOP_V = lpps_pkg::SCALE_W'(DUTY_TOP);
    localparam logic [2:0] LAST_STEP = 3'(lpps_pkg::SUM_W - 1);

    lpps_pkg::state_t state_reg, state_next;

    logic [lpps_pkg::SUM_W-1:0]   dvd_reg, dvd_next;
    logic [2:0]                   rem_reg, rem_next;
    logic [lpps_pkg::CNT_W-1:0]   div_reg, div_next;
    logic [2:0]                   step_reg, step_next;
    logic [lpps_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         lost_reg, lost_next;
    logic signed [lpps_pkg::ERR_W-1:0]  prev_reg, prev_next;
    logic signed [17:0]           pkp_reg, pkp_next;
    logic signed [18:0]           pkd_reg, pkd_next;
    logic signed [lpps_pkg::CORR_W-1:0] corr_reg, corr_next;
    logic [lpps_pkg::PROD_W-1:0]  lprod_reg, lprod_next;
    logic [lpps_pkg::PROD_W-1:0]  rprod_reg, rprod_next;

    logic                         out_valid_reg, out_valid_next;
    logic [lpps_pkg::POS_W-1:0]   o_pos_reg;
    logic                         o_lost_reg;
    logic signed [lpps_pkg::CORR_W-1:0] o_corr_reg;
    logic [lpps_pkg::DUTY_W-1:0]  o_left_reg, o_right_reg;

    logic                         out_free, out_load, start;
    logic [3:0]                   rem_sh;
    logic                         ge;
    logic signed [lpps_pkg::ERR_W-1:0]  err;
    logic signed [lpps_pkg::DIFF_W-1:0] diff;
    logic signed [19:0]           acc, acc_adj;
    logic signed [15:0]           quo;
    logic signed [lpps_pkg::SPD_W-1:0] spd_l, spd_r;
    logic [10:0]                  mag_l, mag_r;
    logic [lpps_pkg::SCALE_W-1:0] sc_l, sc_r;
    logic [lpps_pkg::DUTY_W-1:0]  duty_l, duty_r;

    assign out_free = !out_valid_reg || !out_stall;
    assign start    = (state_reg == lpps_pkg::ST_IDLE) && q_not_empty;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpps_pkg::ST_IDLE:
                if (q_not_empty)
                    state_next = (q_data.count == '0) ? lpps_pkg::ST_PD : lpps_pkg::ST_DIV;
            lpps_pkg::ST_DIV:
                if (step_reg == LAST_STEP)
                    state_next = lpps_pkg::ST_PD;
            lpps_pkg::ST_PD:   state_next = lpps_pkg::ST_SUM;
            lpps_pkg::ST_SUM:  state_next = lpps_pkg::ST_DUTY;
            lpps_pkg::ST_DUTY: state_next = lpps_pkg::ST_OUT;
            lpps_pkg::ST_OUT:
                if (out_free)
                    state_next = lpps_pkg::ST_IDLE;
            default: state_next = lpps_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_ctl.pop   = start;
        out_load    = (state_reg == lpps_pkg::ST_OUT) && out_free;
    end

    // datapath
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[lpps_pkg::SUM_W-1]};
        ge      = ({1'b0, rem_sh} >= {1'b0, div_reg});
        err     = $signed({4'b0, cfg.setpoint}) - $signed({2'b0, pos_reg});
        diff    = $signed({err[lpps_pkg::ERR_W-1], err})
                - $signed({prev_reg[lpps_pkg::ERR_W-1], prev_reg});
        acc     = 20'(pkp_reg) + 20'(pkd_reg);
        acc_adj = acc[19] ? acc + 20'sd15 : acc;
        quo     = 16'(acc_adj >>> 4);
        spd_l   = $signed({4'b0, cfg.base_speed})
                - $signed({corr_reg[lpps_pkg::CORR_W-1], corr_reg, 1'b0});
        spd_r   = $signed({4'b0, cfg.base_speed})
                + $signed({corr_reg[lpps_pkg::CORR_W-1], corr_reg, 1'b0});
        mag_l   = spd_l[lpps_pkg::SPD_W-1] ? '0 : spd_l[10:0];
        mag_r   = spd_r[lpps_pkg::SPD_W-1] ? '0 : spd_r[10:0];
        sc_l    = lprod_reg[lpps_pkg::SCALE_SHIFT +: lpps_pkg::SCALE_W];
        sc_r    = rprod_reg[lpps_pkg::SCALE_SHIFT +: lpps_pkg::SCALE_W];
        duty_l  = (sc_l > TOP_V) ? lpps_pkg::DUTY_W'(TOP_V) : sc_l[lpps_pkg::DUTY_W-1:0];
        duty_r  = (sc_r > TOP_V) ? lpps_pkg::DUTY_W'(TOP_V) : sc_r[lpps_pkg::DUTY_W-1:0];

        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        lost_next  = lost_reg;
        prev_next  = prev_reg;
        pkp_next   = pkp_reg;
        pkd_next   = pkd_reg;
        corr_next  = corr_reg;
        lprod_next = lprod_reg;
        rprod_next = rprod_reg;

        case (state_reg)
            lpps_pkg::ST_IDLE:
            begin
                dvd_next  = q_data.sum;
                rem_next  = '0;
                div_next  = q_data.count;
                step_next = '0;
                lost_next = (q_data.count == '0);
                pos_next  = cfg.lost_position;
            end
            lpps_pkg::ST_DIV:
            begin
                rem_next  = ge ? 3'(rem_sh - div_reg) : rem_sh[2:0];
                dvd_next  = {dvd_reg[lpps_pkg::SUM_W-2:0], ge};
                step_next = step_reg + 3'd1;
                pos_next  = {dvd_reg[lpps_pkg::SUM_W-2:0], ge};
            end
            lpps_pkg::ST_PD:
            begin
                pkp_next  = $signed({1'b0, cfg.kp_gain}) * err;
                pkd_next  = $signed({1'b0, cfg.kd_gain}) * diff;
                prev_next = err;
            end
            lpps_pkg::ST_SUM:
            begin
                if (quo > 16'sd511)
                    corr_next = 10'sd511;
                else if (quo < -16'sd512)
                    corr_next = -10'sd512;
                else
                    corr_next = quo[lpps_pkg::CORR_W-1:0];
            end
            lpps_pkg::ST_DUTY:
            begin
                lprod_next = lpps_pkg::PROD_W'(mag_l * lpps_pkg::SCALE_MULT);
                rprod_next = lpps_pkg::PROD_W'(mag_r * lpps_pkg::SCALE_MULT);
            end
            default: ;
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpps_pkg::ST_IDLE;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        step_reg  <= step_next;
        pos_reg   <= pos_next;
        lost_reg  <= lost_next;
        pkp_reg   <= pkp_next;
        pkd_reg   <= pkd_next;
        corr_reg  <= corr_next;
        lprod_reg <= lprod_next;
        rprod_reg <= rprod_next;
        if (out_load)
        begin
            o_pos_reg   <= pos_reg;
            o_lost_reg  <= lost_reg;
            o_corr_reg  <= corr_reg;
            o_left_reg  <= duty_l;
            o_right_reg <= duty_r;
        end
    end

    assign out_valid  = out_valid_reg;
    assign position   = o_pos_reg;
    assign line_lost  = o_lost_reg;
    assign correction = o_corr_reg;
    assign left_duty  = o_left_reg;
    assign right_duty = o_right_reg;

endmodule
